[rtl/fhd_pkg.sv]
`default_nettype none

package fhd_pkg;

  localparam int WIDTH  = 16;
  localparam int HEIGHT = 16;

  localparam int COL_W  = $clog2(WIDTH);
  localparam int ROW_W  = $clog2(HEIGHT);
  localparam int ADDR_W = ROW_W + COL_W;
  // Rows are laid out on a power-of-two stride so that an address is {row, col}.
  localparam int DEPTH  = HEIGHT << COL_W;

  // floor(x / 3) == (x * 683) >> 11 for every x below 1024.
  localparam logic [9:0] DIV3_MUL = 10'd683;

  typedef logic [7:0]        heat_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    row_t row;
    col_t col;
  } pos_t;

  // Neighborhood of the cell being computed. h_prev is the cell to the left
  // in the current row (already new), cur and nxt are the cell itself and its
  // right neighbor (still old), and the b_* entries are the row below.
  typedef struct packed {
    heat_t h_prev;
    heat_t cur;
    heat_t nxt;
    heat_t b_m1;
    heat_t b_0;
    heat_t b_p1;
  } window_t;

  typedef struct packed {
    logic first_col;
    logic last_col;
    logic bottom;
  } cell_kind_t;

  typedef struct packed {
    logic [3:0] cell_col;
    logic [3:0] cell_row;
    heat_t      heat;
    logic       frame_end;
  } cell_res_t;

  localparam pos_t RESET_POS = '{row: row_t'(HEIGHT - 1), col: '0};

  // Next cell in visit order: left to right, rows from the bottom upward.
  function automatic pos_t pos_adv(pos_t p);
    pos_t n;
    n = p;
    if (p.col == col_t'(WIDTH - 1)) begin
      n.col = '0;
      n.row = (p.row == '0) ? row_t'(HEIGHT - 1) : p.row - row_t'(1);
    end else begin
      n.col = p.col + col_t'(1);
    end
    return n;
  endfunction

  function automatic addr_t addr_of(pos_t p);
    return {p.row, p.col};
  endfunction

  // Address of the cell directly below; wraps for the bottom row, whose
  // neighborhood is never used.
  function automatic addr_t addr_below(pos_t p);
    row_t r;
    r = (p.row == row_t'(HEIGHT - 1)) ? '0 : p.row + row_t'(1);
    return {r, p.col};
  endfunction

  function automatic logic [3:0] low4_col(col_t c);
    logic [31:0] t;
    t = 32'(c);
    return t[3:0];
  endfunction

  function automatic logic [3:0] low4_row(row_t r);
    logic [31:0] t;
    t = 32'(r);
    return t[3:0];
  endfunction

endpackage

`default_nettype wire

[rtl/fhd_heat_ram.sv]
`default_nettype none

module fhd_heat_ram
  import fhd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  we,
  input  wire addr_t waddr,
  input  wire heat_t wdata,
  input  wire addr_t ra_addr,
  input  wire addr_t rb_addr,
  output      heat_t ra_data,
  output      heat_t rb_data
);

  heat_t mem [DEPTH];

  // Both read ports return the old contents when they hit the written address.
  always_ff @(posedge clk) begin
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

[rtl/fhd_cell_calc.sv]
`default_nettype none

module fhd_cell_calc
  import fhd_pkg::*;
(
  input  wire window_t    win,
  input  wire cell_kind_t kind,
  input  wire heat_t      seed_heat,
  input  wire logic [4:0] cooling,
  output      heat_t      heat
);

  logic [10:0] sum;
  logic [9:0]  half;
  logic [19:0] prod;
  heat_t       mean;

  always_comb begin
    sum = 11'(win.cur) + 11'(win.b_0);
    if (!kind.first_col) begin
      sum = sum + 11'(win.h_prev) + 11'(win.b_m1);
    end
    if (!kind.last_col) begin
      sum = sum + 11'(win.nxt) + 11'(win.b_p1);
    end
  end

  // A six-cell sum is halved and then divided by three through a reciprocal.
  assign half = sum[10:1];
  assign prod = 20'(half) * 20'(DIV3_MUL);

  always_comb begin
    if (kind.first_col || kind.last_col) begin
      mean = sum[9:2];
    end else begin
      mean = prod[18:11];
    end
    if (kind.bottom) begin
      heat = seed_heat;
    end else if (mean > heat_t'(cooling)) begin
      heat = mean - heat_t'(cooling);
    end else begin
      heat = '0;
    end
  end

endmodule

`default_nettype wire

[rtl/fhd_out_buf.sv]
`default_nettype none

module fhd_out_buf
  import fhd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire cell_res_t push_res,
  output      logic      push_ready,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      cell_res_t out_res,
  output      heat_t     out_red,
  output      heat_t     out_green,
  output      heat_t     out_blue
);

  typedef struct packed {
    cell_res_t res;
    heat_t     red;
    heat_t     green;
    heat_t     blue;
  } pix_t;

  pix_t       pix_in;
  pix_t       main_r;
  pix_t       skid_r;
  logic       main_v_r;
  logic       skid_v_r;
  logic       pop;
  logic [7:0] scaled;
  logic [8:0] white;

  // Four-band palette: red ramp, green ramp, blue ramp, then blue toward white.
  always_comb begin
    scaled = {push_res.heat[5:0], 2'b00};
    white  = 9'd200 + 9'(scaled);
    pix_in.res = push_res;
    case (push_res.heat[7:6])
      2'd0: begin
        pix_in.red   = scaled;
        pix_in.green = '0;
        pix_in.blue  = '0;
      end
      2'd1: begin
        pix_in.red   = 8'hFF;
        pix_in.green = scaled;
        pix_in.blue  = '0;
      end
      2'd2: begin
        pix_in.red   = 8'hFF;
        pix_in.green = 8'hFF;
        pix_in.blue  = 8'(push_res.heat[5:0]) + {push_res.heat[5:0], 1'b0};
      end
      default: begin
        pix_in.red   = 8'hFF;
        pix_in.green = 8'hFF;
        pix_in.blue  = white[8] ? 8'hFF : white[7:0];
      end
    endcase
  end

  assign pop        = main_v_r && out_ready;
  assign push_ready = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (main_v_r && !pop) begin
        skid_v_r <= 1'b1;
      end else begin
        main_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (main_v_r && !pop) begin
        skid_r <= pix_in;
      end else begin
        main_r <= pix_in;
      end
    end
  end

  assign out_valid = main_v_r;
  assign out_res   = main_r.res;
  assign out_red   = main_r.red;
  assign out_green = main_r.green;
  assign out_blue  = main_r.blue;

endmodule

`default_nettype wire

[rtl/fire_heat_diffusion.sv]
`default_nettype none

// Fire-effect heat diffusion over a WIDTH x HEIGHT frame (package constants,
// 16 x 16 by default). Each input transaction computes the next cell in visit
// order: the bottom row left to right, then each row above it, ending at the
// top row's last column, where out_tlast is set and the scan wraps. Bottom
// cells take seed_heat; other cells take the mean of their in-bounds 3x2
// neighborhood (this row and the one below) minus cooling, clamped at zero.
// The block takes one cell per clock cycle while in_tready is high, limited by
// the loop through the mean of each cell, which feeds the next cell to its right.
// Results are registered on acceptance in an output register backed by a skid
// stage, so a stalled output does not stop the input until both are full. The
// heat frame lives in one memory with two registered read ports, which prefetch
// the neighborhood two cells ahead, and one write port; the first frame after
// reset reads unwritten cells as zero. in_tready stays low after reset until
// primed_r is set, while the first prefetch completes.
module fire_heat_diffusion
  import fhd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,   // seed_heat[7:0], cooling[12:8], zero[15:13]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata,  // cell_col[3:0], cell_row[7:4], heat[15:8],
                                       // red[23:16], green[31:24], blue[39:32]
  output      logic        out_tlast   // frame_end
);

  pos_t       pos_r;
  pos_t       la2_r;
  logic       primed_r;
  logic       first_frame_r;
  logic       byp_r;
  heat_t      byp_h_r;
  addr_t      rb_addr_r;
  window_t    win_r;

  logic       accept;
  logic       buf_ready;
  pos_t       rd_pos;
  addr_t      ra_addr;
  addr_t      rb_addr;
  addr_t      waddr;
  heat_t      ra_data;
  heat_t      rb_data;
  heat_t      heat;
  heat_t      below_nxt;
  cell_kind_t kind;
  cell_res_t  res;
  cell_res_t  out_res;
  heat_t      out_red;
  heat_t      out_green;
  heat_t      out_blue;

  assign in_tready = primed_r && buf_ready;
  assign accept    = in_tvalid && in_tready;

  // The read ports always hold the cell two positions ahead of the scan and the cell below it.
  assign rd_pos  = accept ? pos_adv(la2_r) : la2_r;
  assign ra_addr = addr_of(rd_pos);
  assign rb_addr = addr_below(rd_pos);
  assign waddr   = addr_of(pos_r);

  assign kind.first_col = (pos_r.col == '0);
  assign kind.last_col  = (pos_r.col == col_t'(WIDTH - 1));
  assign kind.bottom    = (pos_r.row == row_t'(HEIGHT - 1));

  // In narrow frames the cell below may be written after its read was issued:
  // the current result or the one written alongside the read replaces it.
  always_comb begin
    if (rb_addr_r == waddr) begin
      below_nxt = heat;
    end else if (byp_r) begin
      below_nxt = byp_h_r;
    end else begin
      below_nxt = rb_data;
    end
  end

  fhd_heat_ram u_ram (
    .clk     (clk),
    .we      (accept),
    .waddr   (waddr),
    .wdata   (heat),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  fhd_cell_calc u_calc (
    .win       (win_r),
    .kind      (kind),
    .seed_heat (in_tdata[7:0]),
    .cooling   (in_tdata[12:8]),
    .heat      (heat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= RESET_POS;
      la2_r         <= pos_adv(pos_adv(RESET_POS));
      primed_r      <= 1'b0;
      first_frame_r <= 1'b1;
      byp_r         <= 1'b0;
    end else begin
      primed_r <= 1'b1;
      byp_r    <= accept && (rb_addr == waddr);
      if (accept) begin
        pos_r <= pos_adv(pos_r);
        la2_r <= rd_pos;
        if (pos_r.row == '0 && kind.last_col) begin
          first_frame_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rb_addr_r <= rb_addr;
    byp_h_r   <= heat;
    if (accept) begin
      win_r.h_prev <= heat;
      win_r.cur    <= win_r.nxt;
      win_r.nxt    <= first_frame_r ? '0 : ra_data;
      win_r.b_m1   <= win_r.b_0;
      win_r.b_0    <= win_r.b_p1;
      win_r.b_p1   <= below_nxt;
    end
  end

  assign res.cell_col  = low4_col(pos_r.col);
  assign res.cell_row  = low4_row(pos_r.row);
  assign res.heat      = heat;
  assign res.frame_end = (pos_r.row == '0) && kind.last_col;

  fhd_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_res   (res),
    .push_ready (buf_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue)
  );

  assign out_tdata = {out_blue, out_green, out_red, out_res.heat,
                      out_res.cell_row, out_res.cell_col};
  assign out_tlast = out_res.frame_end;

endmodule

`default_nettype wire
